// ----- hdl/range_filter_sort_by_distance_macros.svh -----
// Assertion helpers for the checker file (rfsd_checker.sv).
`ifndef RANGE_FILTER_SORT_BY_DISTANCE_MACROS_SVH
`define RANGE_FILTER_SORT_BY_DISTANCE_MACROS_SVH

// consequent checked in the same cycle
`define RFSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfsd check failed (same cycle)");

// consequent checked in the cycle after the antecedent
`define RFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfsd check failed (next cycle)");

`endif

// ----- hdl/rfsd_pkg.sv -----
package rfsd_pkg;

   localparam int COORD_W = 16;
   localparam int ID_W    = 16;
   localparam int DIST_W  = 34;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVER_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVER_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVER_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADAR_RANGE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAB_STRENGTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_RESULTS  = 3'd5;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] dsq;
      logic              pick;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '0;

   typedef struct packed {
      logic      valid;
      logic      last;
      logic      keep;
      entry_type entry;
   } dist_out_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SORT,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        load;
      logic        pair_left;
      logic        pair_right;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_SORT,
      ST_DRAIN
   } rfsd_state_type;

endpackage

// ----- hdl/rfsd_dist.sv -----
module rfsd_dist import rfsd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] obj_x,
   input  logic signed [COORD_W-1:0] obj_y,
   input  logic signed [COORD_W-1:0] obj_z,
   input  logic        [ID_W-1:0]    object_id,
   input  logic        [15:0]        object_mass,
   input  logic                      last_object,
   input  logic signed [COORD_W-1:0] observer_x,
   input  logic signed [COORD_W-1:0] observer_y,
   input  logic signed [COORD_W-1:0] observer_z,
   input  logic        [15:0]        radar_range,
   input  logic        [15:0]        mass_limit,
   output dist_out_type              dout
);

   function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
      logic signed [16:0] d;
      d = {a[15], a} - {b[15], b};
      return d[16] ? 16'(-d) : d[15:0];
   endfunction

   logic            s1_valid_ff;
   logic            s1_last_ff;
   logic            s1_pick_ff;
   logic [ID_W-1:0] s1_id_ff;
   logic [15:0]     s1_mx_ff, s1_my_ff, s1_mz_ff;

   logic            s2_valid_ff;
   logic            s2_last_ff;
   logic            s2_pick_ff;
   logic [ID_W-1:0] s2_id_ff;
   logic [31:0]     s2_sx_ff, s2_sy_ff, s2_sz_ff;
   logic [31:0]     r2_ff;

   logic [DIST_W-1:0] d2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= last_object;
      s1_pick_ff <= object_mass < mass_limit;
      s1_id_ff   <= object_id;
      s1_mx_ff   <= abs_diff(obj_x, observer_x);
      s1_my_ff   <= abs_diff(obj_y, observer_y);
      s1_mz_ff   <= abs_diff(obj_z, observer_z);

      s2_last_ff <= s1_last_ff;
      s2_pick_ff <= s1_pick_ff;
      s2_id_ff   <= s1_id_ff;
      s2_sx_ff   <= {16'b0, s1_mx_ff} * {16'b0, s1_mx_ff};
      s2_sy_ff   <= {16'b0, s1_my_ff} * {16'b0, s1_my_ff};
      s2_sz_ff   <= {16'b0, s1_mz_ff} * {16'b0, s1_mz_ff};
      // range squared tracks the register; the user must keep it static during a scan, the block does not enforce it
      r2_ff      <= {16'b0, radar_range} * {16'b0, radar_range};
   end

   assign d2 = {2'b0, s2_sx_ff} + {2'b0, s2_sy_ff} + {2'b0, s2_sz_ff};

   always_comb begin
      dout.valid       = s2_valid_ff;
      dout.last        = s2_last_ff;
      dout.keep        = d2 < {2'b0, r2_ff};
      dout.entry.valid = 1'b1;
      dout.entry.id    = s2_id_ff;
      dout.entry.dsq   = d2;
      dout.entry.pick  = s2_pick_ff;
   end

endmodule

// ----- hdl/rfsd_cell.sv -----
module rfsd_cell import rfsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic          left_gt,
   output entry_type     q,
   output logic          gt_right
);

   entry_type entry_ff;
   entry_type entry_in;

   assign q = entry_ff;

   // strict compare keeps equal distances in arrival order
   assign gt_right = entry_ff.valid & right_entry.valid & (entry_ff.dsq > right_entry.dsq);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            if (ctrl.load) begin
               entry_in = new_entry;
            end
         end
         CELL_SORT: begin
            if (ctrl.pair_right && gt_right) begin
               entry_in = right_entry;
            end else if (ctrl.pair_left && left_gt) begin
               entry_in = left_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id   <= entry_in.id;
      entry_ff.dsq  <= entry_in.dsq;
      entry_ff.pick <= entry_in.pick;
   end

endmodule

// ----- hdl/range_filter_sort_by_distance.sv -----
// One object per cycle while scanning; busy rises when the last object is taken.
// First result: after the distance stages, odd-even transposition passes over
// the cell chain (with sorting on only) and the response register. Results then
// follow one per cycle, one per kept object up to MAX_OBJECTS (one for an empty
// scan). The receiver cannot stall. Synchronous reset clears the cell valid bits,
// state, counters and CSR registers (sort_results resets to 1).
module range_filter_sort_by_distance import rfsd_pkg::*; #(
   parameter int MAX_OBJECTS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [COORD_W-1:0]   req_obj_x,
   input  logic signed [COORD_W-1:0]   req_obj_y,
   input  logic signed [COORD_W-1:0]   req_obj_z,
   input  logic        [ID_W-1:0]      req_object_id,
   input  logic        [15:0]          req_object_mass,
   input  logic                        req_last_object,
   output logic                        rsp_valid,
   output logic        [ID_W-1:0]      rsp_found_id,
   output logic        [DIST_W-1:0]    rsp_dist_squared,
   output logic                        rsp_pickable,
   output logic                        rsp_any_visible,
   output logic                        rsp_overflowed,
   output logic                        rsp_last_result,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [CSR_DAT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_OBJECTS + 1);

   logic signed [COORD_W-1:0] obs_x_ff, obs_y_ff, obs_z_ff;
   logic [15:0]               range_ff, grab_ff;
   logic                      sort_ff;

   rfsd_state_type   state_ff, state_in;
   logic [CNT_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             busy_ff, busy_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic             rsp_pick_ff, rsp_pick_in;
   logic             rsp_vis_ff, rsp_vis_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic             rsp_last_ff, rsp_last_in;

   logic          accept;
   dist_out_type  dout;
   cell_op_type   op;
   logic          load_en;
   entry_type     cell_q [MAX_OBJECTS];
   logic          cell_gt [MAX_OBJECTS];

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found_id     = rsp_id_ff;
   assign rsp_dist_squared = rsp_dist_ff;
   assign rsp_pickable     = rsp_pick_ff;
   assign rsp_any_visible  = rsp_vis_ff;
   assign rsp_overflowed   = rsp_ovf_ff;
   assign rsp_last_result  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_x_ff <= '0;
         obs_y_ff <= '0;
         obs_z_ff <= '0;
         range_ff <= '0;
         grab_ff  <= '0;
         sort_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OBSERVER_X:    obs_x_ff <= csr_wdata;
            CSR_OBSERVER_Y:    obs_y_ff <= csr_wdata;
            CSR_OBSERVER_Z:    obs_z_ff <= csr_wdata;
            CSR_RADAR_RANGE:   range_ff <= csr_wdata;
            CSR_GRAB_STRENGTH: grab_ff  <= csr_wdata;
            CSR_SORT_RESULTS:  sort_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   rfsd_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .obj_x         (req_obj_x),
      .obj_y         (req_obj_y),
      .obj_z         (req_obj_z),
      .object_id     (req_object_id),
      .object_mass   (req_object_mass),
      .last_object   (req_last_object),
      .observer_x    (obs_x_ff),
      .observer_y    (obs_y_ff),
      .observer_z    (obs_z_ff),
      .radar_range   (range_ff),
      .mass_limit    (grab_ff),
      .dout          (dout)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      busy_in      = busy_ff;
      op           = CELL_HOLD;
      load_en      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_vis_in   = cell_q[0].valid;
      rsp_id_in    = cell_q[0].valid ? cell_q[0].id : '0;
      rsp_dist_in  = cell_q[0].valid ? cell_q[0].dsq : '0;
      rsp_pick_in  = cell_q[0].valid & cell_q[0].pick;
      rsp_ovf_in   = ovf_ff;
      rsp_last_in  = count_ff <= CNT_W'(1);

      if (accept && req_last_object) begin
         busy_in = 1'b1;
      end

      unique case (state_ff)
         ST_SCAN: begin
            if (dout.valid) begin
               if (dout.keep) begin
                  if (count_ff < CNT_W'(MAX_OBJECTS)) begin
                     load_en  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (dout.last) begin
                  phase_in = '0;
                  state_in = sort_ff ? ST_SORT : ST_DRAIN;
               end
            end
         end
         ST_SORT: begin
            op       = CELL_SORT;
            phase_in = phase_ff + CNT_W'(1);
            if (phase_ff == CNT_W'(MAX_OBJECTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // word leaves from cell 0, chain moves one toward the head
            op           = CELL_SHIFT;
            rsp_valid_in = 1'b1;
            if (count_ff <= CNT_W'(1)) begin
               state_in = ST_SCAN;
               count_in = '0;
               ovf_in   = 1'b0;
               busy_in  = 1'b0;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         phase_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff   <= rsp_id_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_pick_ff <= rsp_pick_in;
      rsp_vis_ff  <= rsp_vis_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
      localparam logic POS_ODD   = 1'(i % 2);
      localparam logic HAS_LEFT  = (i > 0);
      localparam logic HAS_RIGHT = (i < MAX_OBJECTS - 1);

      cell_ctrl_type ctrl;
      entry_type     left_entry;
      entry_type     right_entry;
      logic          left_gt;

      always_comb begin
         ctrl.op         = op;
         ctrl.load       = load_en && (count_ff == CNT_W'(i));
         ctrl.pair_right = HAS_RIGHT && (POS_ODD == phase_ff[0]);
         ctrl.pair_left  = HAS_LEFT && (POS_ODD != phase_ff[0]);
      end

      if (i == 0) begin : g_head
         assign left_entry = EMPTY_ENTRY;
         assign left_gt    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_q[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == MAX_OBJECTS - 1) begin : g_tail
         assign right_entry = EMPTY_ENTRY;
      end else begin : g_next
         assign right_entry = cell_q[i+1];
      end

      rfsd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (dout.entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_gt     (left_gt),
         .q           (cell_q[i]),
         .gt_right    (cell_gt[i])
      );
   end

endmodule

// ----- hdl/rfsd_checker.sv -----
`include "range_filter_sort_by_distance_macros.svh"

module rfsd_checker import rfsd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_last_object,
   input logic              rsp_valid,
   input logic [ID_W-1:0]   rsp_found_id,
   input logic [DIST_W-1:0] rsp_dist_squared,
   input logic              rsp_pickable,
   input logic              rsp_any_visible,
   input logic              rsp_last_result
);

   // a scan's last object locks out the input side
   `RFSD_ASSERT_NEXT(a_last_sets_busy, clock, reset, start && !busy && req_last_object, busy)

   // results other than the final one only appear while the scan is held
   `RFSD_ASSERT_NOW(a_mid_word_busy, clock, reset, rsp_valid && !rsp_last_result, busy)

   // final word releases the input side and is not followed at once
   `RFSD_ASSERT_NOW(a_last_word_idle, clock, reset, rsp_valid && rsp_last_result, !busy)
   `RFSD_ASSERT_NEXT(a_last_word_gap, clock, reset, rsp_valid && rsp_last_result, !rsp_valid)

   // empty scan: single zeroed word
   `RFSD_ASSERT_NOW(a_empty_word, clock, reset, rsp_valid && !rsp_any_visible,
      rsp_last_result && rsp_found_id == '0 && rsp_dist_squared == '0 && !rsp_pickable)

endmodule

bind range_filter_sort_by_distance rfsd_checker u_rfsd_checker (.*);
